FILE: rtl/gzw_pkg.sv
// ----------------------------------------------------------------------------
// gzw_pkg
// Shared widths and constants for the grid line zone walker.
// ----------------------------------------------------------------------------
package gzw_pkg;

    localparam int COORD_WIDTH = 24;                      // input coordinate width
    localparam int DIFF_W      = COORD_WIDTH + 1;         // segment direction width
    localparam int WORLD_W     = 23;                      // world size register width
    localparam int ZONES_W     = 5;                       // zone count register width
    localparam int MUL_W       = 32;                      // shared multiplier operand width
    localparam int PROD_W      = 2 * MUL_W;               // shared multiplier product width
    localparam int DIV_BITS    = COORD_WIDTH + ZONES_W - 1; // dividend magnitude bits
    localparam int DIV_CNT_W   = $clog2(DIV_BITS);
    localparam int ZONE_W      = DIV_BITS + 2;            // signed zone coordinate width
    localparam int MAX_STEPS   = 63;                      // results per segment cap
    localparam int STEP_W      = $clog2(MAX_STEPS + 1);
    localparam int IDX_W       = 11;                      // zone index width
    localparam int REASON_W    = 2;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [REASON_W-1:0] {
        RSN_END   = 2'd0,
        RSN_LEFT  = 2'd1,
        RSN_CAP   = 2'd2,
        RSN_RSVD  = 2'd3
    } t_reason;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORLD_W = 2'd0,
        CFG_WORLD_H = 2'd1,
        CFG_ZONES_X = 2'd2,
        CFG_ZONES_Y = 2'd3
    } t_cfg_idx;

endpackage

FILE: rtl/gzw_mul.sv
// ----------------------------------------------------------------------------
// gzw_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module gzw_mul (
    input  logic                                i_clk,
    input  logic signed [gzw_pkg::MUL_W-1:0]    i_a,
    input  logic signed [gzw_pkg::MUL_W-1:0]    i_b,
    output logic signed [gzw_pkg::PROD_W-1:0]   o_p
);

    logic signed [gzw_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= gzw_pkg::PROD_W'(i_a) * gzw_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

FILE: rtl/gzw_div.sv
// ----------------------------------------------------------------------------
// gzw_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module gzw_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [gzw_pkg::MUL_W-1:0]     i_num,
    input  logic [gzw_pkg::WORLD_W-1:0]          i_den,
    output logic                                 o_done,
    output logic signed [gzw_pkg::ZONE_W-1:0]    o_quo
);

    logic                                r_busy, n_busy;
    logic                                r_done, n_done;
    logic [gzw_pkg::DIV_CNT_W-1:0]       r_cnt, n_cnt;
    logic                                r_neg, n_neg;
    logic [gzw_pkg::DIV_BITS-1:0]        r_num, n_num;
    logic [gzw_pkg::WORLD_W-1:0]         r_rem, n_rem;
    logic [gzw_pkg::WORLD_W-1:0]         r_den, n_den;
    logic [gzw_pkg::MUL_W-1:0]           num_mag;
    logic [gzw_pkg::WORLD_W:0]           trial;
    logic                                ge;

    assign num_mag = i_num[gzw_pkg::MUL_W-1] ? gzw_pkg::MUL_W'(-i_num) : i_num;
    assign trial   = {r_rem, r_num[gzw_pkg::DIV_BITS-1]};
    assign ge      = trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_neg  = i_num[gzw_pkg::MUL_W-1];
            n_num  = num_mag[gzw_pkg::DIV_BITS-1:0];
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = ge ? gzw_pkg::WORLD_W'(trial - {1'b0, r_den})
                       : trial[gzw_pkg::WORLD_W-1:0];
            n_num = {r_num[gzw_pkg::DIV_BITS-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == gzw_pkg::DIV_CNT_W'(gzw_pkg::DIV_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_neg <= n_neg;
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -signed'(gzw_pkg::ZONE_W'(r_num))
                          : signed'(gzw_pkg::ZONE_W'(r_num));

endmodule

FILE: rtl/grid_line_zone_walker.sv
// ----------------------------------------------------------------------------
// grid_line_zone_walker
// Walks the zones of a uniform grid crossed by a line segment.
// ----------------------------------------------------------------------------
// One segment word in, one word per zone out, start zone first. After a
// segment is accepted, setup runs 6 products through the shared
// multiplier, then 4 zone divisions through the bit-serial divider
// (start, 28 quotient bits, hand-off). Each zone then runs the crossing
// test through the multiply sequence, or takes a straight step, or is
// the final zone; a stalled output holds it. Up to 63 zones. The input
// is not ready during a walk. If any configuration register is zero the
// segment yields no words.
module grid_line_zone_walker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [95:0]  i_s_axis_tdata,   // start_x, start_y, end_x, end_y
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [15:0]  o_m_axis_tdata,   // zone_index, zero fill
    output logic         o_m_axis_tlast,   // last
    output logic [1:0]   o_m_axis_tuser,   // end_reason
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [22:0]  i_cfg_data
);

    localparam int CW = gzw_pkg::COORD_WIDTH;
    localparam int DW = gzw_pkg::DIFF_W;
    localparam int MW = gzw_pkg::MUL_W;
    localparam int PW = gzw_pkg::PROD_W;
    localparam int ZW = gzw_pkg::ZONE_W;
    localparam int NW = gzw_pkg::STEP_W;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_PRE  = 10'b00_0000_0010,
        S_DIV  = 10'b00_0000_0100,
        S_CHK  = 10'b00_0000_1000,
        S_XN   = 10'b00_0001_0000,
        S_YN   = 10'b00_0010_0000,
        S_A1   = 10'b00_0100_0000,
        S_PS   = 10'b00_1000_0000,
        S_DEC  = 10'b01_0000_0000,
        S_EMIT = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [gzw_pkg::WORLD_W-1:0] r_ww, r_wh;
    logic [gzw_pkg::ZONES_W-1:0] r_zx, r_zy;

    logic [2:0]            r_k, n_k;
    logic [1:0]            r_j, n_j;
    logic                  r_dstart, n_dstart;
    logic signed [CW-1:0]  r_sx, n_sx, r_sy, n_sy, r_ex, n_ex, r_ey, n_ey;
    logic signed [DW-1:0]  r_dx, n_dx, r_dy, n_dy;
    logic signed [MW-1:0]  r_sxzx, n_sxzx, r_syzy, n_syzy, r_exzx, n_exzx, r_eyzy, n_eyzy;
    logic signed [MW-1:0]  r_b1, n_b1, r_b2, n_b2, r_a1, n_a1, r_a2, n_a2;
    logic signed [PW-1:0]  r_q, n_q;
    logic signed [ZW-1:0]  r_x, n_x, r_y, n_y, r_tx, n_tx, r_ty, n_ty;
    logic signed [ZW-1:0]  r_cx, n_cx, r_cy, n_cy;
    logic [NW-1:0]         r_n, n_n;
    logic                  r_last, n_last;
    gzw_pkg::t_reason      r_reason, n_reason;

    logic                  r_ovalid, n_ovalid;
    logic [gzw_pkg::IDX_W-1:0] r_odata, n_odata;
    logic                  r_olast, n_olast;
    gzw_pkg::t_reason      r_ouser, n_ouser;

    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [PW-1:0]  mul_p;
    logic signed [MW-1:0]  div_num;
    logic [gzw_pkg::WORLD_W-1:0] div_den;
    logic                  div_done;
    logic signed [ZW-1:0]  div_quo;

    logic signed [MW-1:0]  zxs, zys;
    logic signed [ZW-1:0]  zxz, zyz;
    logic                  cfg_zero, in_acc, slot_free, coarse_out, ystep;
    logic signed [PW-1:0]  sum;
    logic signed [ZW-1:0]  x_up, x_dn, y_up, y_dn;
    logic [5:0]            zp1;
    logic [gzw_pkg::IDX_W-1:0] idx;

    assign zxs = signed'(MW'(r_zx));
    assign zys = signed'(MW'(r_zy));
    assign zxz = signed'(ZW'(r_zx));
    assign zyz = signed'(ZW'(r_zy));
    assign cfg_zero = (r_ww == '0) || (r_wh == '0) || (r_zx == '0) || (r_zy == '0);
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free = !r_ovalid || i_m_axis_tready;
    assign coarse_out = (r_x < -ZW'(1)) || (r_x > zxz + ZW'(1))
                     || (r_y < -ZW'(1)) || (r_y > zyz + ZW'(1));
    assign x_up = r_x + ZW'(1);
    assign x_dn = r_x - ZW'(1);
    assign y_up = r_y + ZW'(1);
    assign y_dn = r_y - ZW'(1);
    assign sum  = r_q + mul_p;
    assign zp1  = {1'b0, r_zx} + 6'd1;
    assign idx  = r_x[10:0] + 11'(r_y[10:0] * zp1);

    // steps follow the sign of the cross product and the direction quadrant; a tie steps in y when dy > 0, else in x
    always_comb begin
        if (r_dy > 0)
            ystep = (r_dx > 0) ? !sum[PW-1] : (sum[PW-1] || sum == '0);
        else
            ystep = (r_dx > 0) ? sum[PW-1] : (!sum[PW-1] && sum != '0);
    end

    gzw_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    gzw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        unique case (r_j)
            2'd0:    div_num = r_sxzx;
            2'd1:    div_num = r_syzy;
            2'd2:    div_num = r_exzx;
            default: div_num = r_eyzy;
        endcase
        div_den = r_j[0] ? r_wh : r_ww;
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_PRE: begin
                unique case (r_k)
                    3'd0:    begin mul_a = MW'(r_sx); mul_b = zxs; end
                    3'd1:    begin mul_a = MW'(r_sy); mul_b = zys; end
                    3'd2:    begin mul_a = MW'(r_ex); mul_b = zxs; end
                    3'd3:    begin mul_a = MW'(r_ey); mul_b = zys; end
                    3'd4:    begin mul_a = MW'(r_dx); mul_b = zxs; end
                    3'd5:    begin mul_a = MW'(r_dy); mul_b = zys; end
                    default: begin mul_a = '0;        mul_b = '0;  end
                endcase
            end
            S_XN: begin
                mul_a = MW'((r_dx > 0) ? x_up : r_x);
                mul_b = signed'(MW'(r_ww));
            end
            S_YN: begin
                mul_a = MW'((r_dy > 0) ? y_up : r_y);
                mul_b = signed'(MW'(r_wh));
            end
            S_A1: begin mul_a = r_a2; mul_b = r_b2; end
            S_PS: begin mul_a = r_a1; mul_b = r_b1; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_k = r_k;  n_j = r_j;  n_dstart = 1'b0;
        n_sx = r_sx; n_sy = r_sy; n_ex = r_ex; n_ey = r_ey;
        n_dx = r_dx; n_dy = r_dy;
        n_sxzx = r_sxzx; n_syzy = r_syzy; n_exzx = r_exzx; n_eyzy = r_eyzy;
        n_b1 = r_b1; n_b2 = r_b2; n_a1 = r_a1; n_a2 = r_a2; n_q = r_q;
        n_x = r_x; n_y = r_y; n_tx = r_tx; n_ty = r_ty; n_cx = r_cx; n_cy = r_cy;
        n_n = r_n; n_last = r_last; n_reason = r_reason;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_odata = r_odata; n_olast = r_olast; n_ouser = r_ouser;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && !cfg_zero) begin
                    n_sx = signed'(i_s_axis_tdata[23:0]);
                    n_sy = signed'(i_s_axis_tdata[47:24]);
                    n_ex = signed'(i_s_axis_tdata[71:48]);
                    n_ey = signed'(i_s_axis_tdata[95:72]);
                    n_dx = DW'(n_ex) - DW'(n_sx);
                    n_dy = DW'(n_ey) - DW'(n_sy);
                    n_k = '0;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                unique case (r_k)
                    3'd1:    n_sxzx = MW'(mul_p);
                    3'd2:    n_syzy = MW'(mul_p);
                    3'd3:    n_exzx = MW'(mul_p);
                    3'd4:    n_eyzy = MW'(mul_p);
                    3'd5:    n_b1   = MW'(mul_p);
                    3'd6:    n_b2   = MW'(mul_p);
                    default: ;
                endcase
                n_k = r_k + 3'd1;
                if (r_k == 3'd6) begin
                    n_j = '0;
                    n_dstart = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    unique case (r_j)
                        2'd0:    n_x  = div_quo;
                        2'd1:    n_y  = div_quo;
                        2'd2:    n_tx = div_quo;
                        default: n_ty = div_quo;
                    endcase
                    n_j = r_j + 2'd1;
                    if (r_j == 2'd3) begin
                        n_n = NW'(1);
                        n_state = S_CHK;
                    end else begin
                        n_dstart = 1'b1;
                    end
                end
            end
            S_CHK: begin
                n_cx = r_x;
                n_cy = r_y;
                n_reason = gzw_pkg::RSN_END;
                n_last = 1'b0;
                n_state = S_EMIT;
                if (r_x == r_tx && r_y == r_ty) begin
                    n_last = 1'b1;
                end else if (r_n >= NW'(gzw_pkg::MAX_STEPS)) begin
                    n_last = 1'b1;
                    n_reason = gzw_pkg::RSN_CAP;
                end else if (coarse_out) begin
                    n_last = 1'b1;
                    n_reason = gzw_pkg::RSN_LEFT;
                end else if (r_dx == '0 || r_dy == '0) begin
                    if (r_dx == '0)
                        n_cy = (r_dy > 0) ? y_up : y_dn;
                    else
                        n_cx = (r_dx > 0) ? x_up : x_dn;
                    if (n_cx > zxz || n_cy > zyz || n_cx < 0 || n_cy < 0) begin
                        n_last = 1'b1;
                        n_reason = gzw_pkg::RSN_LEFT;
                    end
                end else begin
                    n_state = S_XN;
                end
            end
            S_XN: n_state = S_YN;
            S_YN: begin
                n_a2 = MW'(mul_p) - r_sxzx;
                n_state = S_A1;
            end
            S_A1: begin
                n_a1 = r_syzy - MW'(mul_p);
                n_state = S_PS;
            end
            S_PS: begin
                n_q = mul_p;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (ystep)
                    n_cy = (r_dy > 0) ? y_up : y_dn;
                else
                    n_cx = (r_dx > 0) ? x_up : x_dn;
                if (n_cx > zxz || n_cy > zyz || n_cx < 0 || n_cy < 0) begin
                    n_last = 1'b1;
                    n_reason = gzw_pkg::RSN_LEFT;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_odata = idx;
                    n_olast = r_last;
                    n_ouser = r_last ? r_reason : gzw_pkg::RSN_END;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_x = r_cx;
                        n_y = r_cy;
                        n_n = r_n + NW'(1);
                        n_state = S_CHK;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dstart <= 1'b0;
            r_ovalid <= 1'b0;
            r_n      <= '0;
            r_ww     <= gzw_pkg::WORLD_W'(65536);
            r_wh     <= gzw_pkg::WORLD_W'(65536);
            r_zx     <= gzw_pkg::ZONES_W'(8);
            r_zy     <= gzw_pkg::ZONES_W'(8);
        end else begin
            r_state  <= n_state;
            r_dstart <= n_dstart;
            r_ovalid <= n_ovalid;
            r_n      <= n_n;
            if (i_cfg_valid) begin
                unique case (gzw_pkg::t_cfg_idx'(i_cfg_index))
                    gzw_pkg::CFG_WORLD_W: r_ww <= i_cfg_data;
                    gzw_pkg::CFG_WORLD_H: r_wh <= i_cfg_data;
                    gzw_pkg::CFG_ZONES_X: r_zx <= i_cfg_data[gzw_pkg::ZONES_W-1:0];
                    gzw_pkg::CFG_ZONES_Y: r_zy <= i_cfg_data[gzw_pkg::ZONES_W-1:0];
                    default: ;
                endcase
            end
        end
        r_k <= n_k;  r_j <= n_j;
        r_sx <= n_sx; r_sy <= n_sy; r_ex <= n_ex; r_ey <= n_ey;
        r_dx <= n_dx; r_dy <= n_dy;
        r_sxzx <= n_sxzx; r_syzy <= n_syzy; r_exzx <= n_exzx; r_eyzy <= n_eyzy;
        r_b1 <= n_b1; r_b2 <= n_b2; r_a1 <= n_a1; r_a2 <= n_a2; r_q <= n_q;
        r_x <= n_x; r_y <= n_y; r_tx <= n_tx; r_ty <= n_ty; r_cx <= n_cx; r_cy <= n_cy;
        r_last <= n_last; r_reason <= n_reason;
        r_odata <= n_odata; r_olast <= n_olast; r_ouser <= n_ouser;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {5'b0, r_odata};
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_ouser;
    assign o_cfg_ready     = 1'b1;

`ifndef SYNTHESIS
    a_reason_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tuser == gzw_pkg::RSN_END)
        else $error("end reason on a word that is not last");
    a_reason_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser != gzw_pkg::RSN_RSVD)
        else $error("reserved end reason");
    a_step_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(gzw_pkg::MAX_STEPS))
        else $error("result count beyond cap");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !cfg_zero |=> !o_s_axis_tready)
        else $error("ready during a walk");
`endif

endmodule
